### hw/rtl/salc_pkg.sv
package salc_pkg;

  // defaults for the top level parameters
  localparam int DEF_MAX_SET_BITS = 8;
  localparam int DEF_MAX_WAYS     = 8;
  localparam int DEF_ADDR_BITS    = 64;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd2;

  localparam logic [3:0] RST_SET_INDEX_BITS    = 4'd4;
  localparam logic [4:0] RST_BLOCK_OFFSET_BITS = 5'd4;
  localparam logic [3:0] RST_WAYS_IN_USE       = 4'd1;

  // access kinds
  localparam int REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;

  localparam int IN_TDATA_W  = 64;
  localparam int CNT_W       = 32;
  localparam int OUT_BITS    = 3 + 3 * CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x, input logic en);
    sat_inc = (en && x != CNT_MAX) ? x + 1'b1 : x;
  endfunction

endpackage

### hw/rtl/set_assoc_lru_cache_sim.sv
// Set-associative cache simulator with LRU replacement. Each request carries a
// byte address and an access kind; the block looks up the set picked by the
// address, reports hit, miss and eviction and the saturating running totals.
// A set lives as one row (valid bits, tags, ages of all ways) in a synchronous
// memory: a request has a row read, then a tag compare, update and write back;
// no new request is taken until the write back, which waits while the output
// register holds an untaken result. A finished result waits there while the next
// request is read. The cache is empty after reset with no clearing pass; the user
// must write configuration only while idle, which the block does not enforce.
module set_assoc_lru_cache_sim import salc_pkg::*; #(
  parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
  parameter int MAX_WAYS     = DEF_MAX_WAYS,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,  // address
  input  logic [REQ_W-1:0]       in_tuser,  // req_type
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // was_hit, was_miss, was_eviction, hit_total, miss_total, eviction_total, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W = $clog2(MAX_WAYS + 1) > 4 ? $clog2(MAX_WAYS + 1) : 4;
  localparam int ROW_W  = MAX_WAYS * (1 + ADDR_BITS + RANK_W);
  localparam int SH_W   = 7;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic [3:0] cfg_s_r;
  logic [4:0] cfg_b_r;
  logic [3:0] cfg_e_r;

  logic                    state_r;
  logic [ADDR_BITS-1:0]    tag_r;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [REQ_W-1:0]        req_r;

  logic                  out_vld_r;
  logic                  o_hit_r;
  logic                  o_miss_r;
  logic                  o_evict_r;
  logic [CNT_W-1:0]      hit_cnt_r;
  logic [CNT_W-1:0]      miss_cnt_r;
  logic [CNT_W-1:0]      evict_cnt_r;
  logic [CNT_W-1:0]      hit_cnt_nxt;

  logic                    in_acc;
  logic                    go;
  logic                    mem_we;
  logic [ADDR_BITS-1:0]    addr;
  logic [SH_W-1:0]         s_eff;
  logic [SH_W-1:0]         shift;
  logic [ADDR_BITS-1:0]    tag_nxt;
  logic [ADDR_BITS-1:0]    addr_sh;
  logic [MAX_SET_BITS-1:0] set_nxt;
  logic [WCNT_W-1:0]       nways;

  logic [ROW_W-1:0]                   rd_row;
  logic [ROW_W-1:0]                   wr_row;
  logic [MAX_WAYS-1:0]                valid_i;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_i;
  logic [MAX_WAYS-1:0][RANK_W-1:0]    ranks_i;
  logic [MAX_WAYS-1:0]                valid_o;
  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_o;
  logic [MAX_WAYS-1:0][RANK_W-1:0]    ranks_o;
  lookup_res_t                        res;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign go        = (state_r == ST_LOOK) && (!out_vld_r || out_tready);
  assign mem_we    = go;

  // set index and tag of an incoming request
  always_comb begin
    addr    = in_tdata[ADDR_BITS-1:0];
    s_eff   = (SH_W'(cfg_s_r) > SH_W'(MAX_SET_BITS)) ? SH_W'(MAX_SET_BITS) : SH_W'(cfg_s_r);
    shift   = SH_W'(cfg_b_r) + s_eff;
    tag_nxt = (shift >= SH_W'(ADDR_BITS)) ? '0 : (addr >> shift);
    addr_sh = addr >> cfg_b_r;
    set_nxt = addr_sh[MAX_SET_BITS-1:0] & ~({MAX_SET_BITS{1'b1}} << s_eff);
    if (cfg_e_r == '0) begin
      nways = WCNT_W'(1);
    end else if (WCNT_W'(cfg_e_r) > WCNT_W'(MAX_WAYS)) begin
      nways = WCNT_W'(MAX_WAYS);
    end else begin
      nways = WCNT_W'(cfg_e_r);
    end
  end

  salc_set_mem #(
    .ADDR_W (MAX_SET_BITS),
    .ROW_W  (ROW_W),
    .CLR_W  (MAX_WAYS * RANK_W > MAX_WAYS ? MAX_WAYS : MAX_WAYS * RANK_W)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (set_nxt),
    .rd_data (rd_row),
    .wr_en   (mem_we),
    .wr_addr (set_r),
    .wr_data (wr_row)
  );

  assign {ranks_i, tags_i, valid_i} = rd_row;
  assign wr_row = {ranks_o, tags_o, valid_o};

  salc_lookup #(
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_BITS (ADDR_BITS),
    .RANK_W    (RANK_W),
    .WCNT_W    (WCNT_W)
  ) u_lookup (
    .valid_i (valid_i),
    .tags_i  (tags_i),
    .ranks_i (ranks_i),
    .tag     (tag_r),
    .nways   (nways),
    .valid_o (valid_o),
    .tags_o  (tags_o),
    .ranks_o (ranks_o),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_s_r <= RST_SET_INDEX_BITS;
      cfg_b_r <= RST_BLOCK_OFFSET_BITS;
      cfg_e_r <= RST_WAYS_IN_USE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SET_INDEX_BITS:    cfg_s_r <= cfg_wdata[3:0];
        CFG_BLOCK_OFFSET_BITS: cfg_b_r <= cfg_wdata;
        CFG_WAYS_IN_USE:       cfg_e_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_r <= tag_nxt;
      set_r <= set_nxt;
      req_r <= in_tuser;
    end
  end

  // a modify counts the lookup and then one more hit for the store
  assign hit_cnt_nxt = sat_inc(sat_inc(hit_cnt_r, res.hit), req_r == REQ_MODIFY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_vld_r   <= 1'b0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
    end else begin
      if (in_acc) begin
        state_r <= ST_LOOK;
      end else if (go) begin
        state_r <= ST_IDLE;
      end
      if (go) begin
        out_vld_r   <= 1'b1;
        hit_cnt_r   <= hit_cnt_nxt;
        miss_cnt_r  <= sat_inc(miss_cnt_r, !res.hit);
        evict_cnt_r <= sat_inc(evict_cnt_r, res.evict);
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      o_hit_r   <= res.hit;
      o_miss_r  <= !res.hit;
      o_evict_r <= res.evict;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, evict_cnt_r, miss_cnt_r, hit_cnt_r,
                       o_evict_r, o_miss_r, o_hit_r};

  // read and write back of the set memory never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !mem_we) else $error("set read overlaps write back");

  a_hit_xor_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (o_hit_r ^ o_miss_r) && (!o_evict_r || o_miss_r))
    else $error("inconsistent result flags");

  a_miss_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(go) |-> $stable(miss_cnt_r) && $stable(hit_cnt_r))
    else $error("totals moved without a lookup");

  a_look_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK) && !go |=> (state_r == ST_LOOK) && $stable(set_r))
    else $error("stalled lookup lost its set");

endmodule

### hw/rtl/salc_set_mem.sv
module salc_set_mem import salc_pkg::*; #(
  parameter int ADDR_W = DEF_MAX_SET_BITS,
  parameter int ROW_W  = 64,
  parameter int CLR_W  = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ROW_W-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ROW_W-1:0]  wr_data
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [ROW_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_vld_r;
  logic [ROW_W-1:0] rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // one bit per row: a row never written reads as a cleared set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  // the low CLR_W bits hold the line valid bits, the top CLR_W bits lie in the ranks
  always_comb begin
    rd_data = rd_data_r;
    if (!rd_vld_r) begin
      rd_data[CLR_W-1:0]           = '0;
      rd_data[ROW_W-1 -: CLR_W]    = '0;
    end
  end

endmodule

### hw/rtl/salc_lookup.sv
module salc_lookup import salc_pkg::*; #(
  parameter int MAX_WAYS  = DEF_MAX_WAYS,
  parameter int ADDR_BITS = DEF_ADDR_BITS,
  parameter int RANK_W    = 3,
  parameter int WCNT_W    = 4
) (
  input  logic [MAX_WAYS-1:0]                valid_i,
  input  logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_i,
  input  logic [MAX_WAYS-1:0][RANK_W-1:0]    ranks_i,
  input  logic [ADDR_BITS-1:0]               tag,
  input  logic [WCNT_W-1:0]                  nways,
  output logic [MAX_WAYS-1:0]                valid_o,
  output logic [MAX_WAYS-1:0][ADDR_BITS-1:0] tags_o,
  output logic [MAX_WAYS-1:0][RANK_W-1:0]    ranks_o,
  output lookup_res_t                        res
);

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] sel;
  logic [MAX_WAYS-1:0] free_sel;
  logic [MAX_WAYS-1:0] lru_sel;
  logic                hit;
  logic                have_free;
  logic                was_valid;
  logic [RANK_W-1:0]   old_age;
  logic [RANK_W-1:0]   best;
  logic                found;

  always_comb begin
    for (int k = 0; k < MAX_WAYS; k++) begin
      in_use[k]  = WCNT_W'(k) < nways;
      hit_vec[k] = in_use[k] && valid_i[k] && (tags_i[k] == tag);
    end
    hit       = |hit_vec;
    have_free = |(in_use & ~valid_i);

    // lowest matching way
    found = 1'b0;
    sel   = '0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (hit_vec[k] && !found) begin
        sel[k] = 1'b1;
        found  = 1'b1;
      end
    end

    // highest free way
    free_sel = '0;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (in_use[k] && !valid_i[k]) begin
        free_sel    = '0;
        free_sel[k] = 1'b1;
      end
    end

    // oldest way, lowest index on a tie, way 0 when all ages are zero
    best    = '0;
    lru_sel = '0;
    lru_sel[0] = 1'b1;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (in_use[k] && ranks_i[k] > best) begin
        best       = ranks_i[k];
        lru_sel    = '0;
        lru_sel[k] = 1'b1;
      end
    end

    if (!hit) begin
      sel = have_free ? free_sel : lru_sel;
    end
    was_valid = hit || !have_free;

    old_age = '1;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (sel[k]) begin
        old_age = ranks_i[k];
      end
    end

    valid_o = valid_i;
    tags_o  = tags_i;
    ranks_o = ranks_i;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (sel[k]) begin
        ranks_o[k] = '0;
        if (!hit) begin
          valid_o[k] = 1'b1;
          tags_o[k]  = tag;
        end
      end else if (in_use[k] && valid_i[k] && ranks_i[k] != RANK_MAX &&
                   (!was_valid || ranks_i[k] < old_age)) begin
        ranks_o[k] = ranks_i[k] + 1'b1;
      end
    end

    res.hit   = hit;
    res.evict = !hit && !have_free;
  end

endmodule
